>>> hw/rtl/fsniff_pkg.sv
// fsniff_pkg: shared types and constants of the FASTA/FASTQ format sniffer.
// Used by fsniff_classify, fsniff_tracker and fasta_fastq_format_sniffer.
// No dependencies.
package fsniff_pkg;

    // kind of the first byte of a line
    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GT    = 2'd1,
        KIND_AT    = 2'd2,
        KIND_PLUS  = 2'd3
    } kind_t;

    typedef struct packed {
        logic  newline;
        logic  printable;
        logic  nucleotide;
        kind_t kind;
    } byte_class_t;

    typedef struct packed {
        logic is_fasta;
        logic is_fastq;
    } verdict_t;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;
    localparam logic [7:0] CHAR_GT      = 8'h3E;
    localparam logic [7:0] CHAR_AT      = 8'h40;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_T       = 8'h54;
    localparam logic [7:0] CHAR_N       = 8'h4E;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    localparam logic [2:0] LINE_LIMIT      = 3'd5;
    localparam logic [2:0] FASTA_MIN_LINES = 3'd2;
    localparam logic [2:0] FASTQ_MIN_LINES = 3'd4;
    localparam logic [1:0] LEN_MAX         = 2'd2;

endpackage

>>> hw/rtl/fasta_fastq_format_sniffer.sv
// fasta_fastq_format_sniffer: top level of the FASTA/FASTQ format sniffer.
// Depends on fsniff_pkg, fsniff_classify and fsniff_tracker.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per file byte in
//   data_byte, or an end-of-file marker (end_of_file = 1, data_byte unused).
//   Output channel (out_valid/out_ready) carries one verdict word per marker:
//   is_fasta_single_line, is_fastq and is_fastx. Data bytes give no word.
//   Only the first five lines of a file are examined.
//   Path: a marker is classified from the input register and its verdict
//   is then held in the output register until out_ready takes it.
//   Throughput: one word per cycle while no marker is stalled; the per-byte
//   work is one classify and one state update from input register to line state.
//   Stall: while a verdict waits on out_ready, data bytes keep flowing;
//   only a following marker waits in the input register, and in_ready drops
//   once that register is occupied by a marker that cannot move.
//   Reset: clears all line state, the input register and the output
//   register; the block then expects the first byte of a new file. After
//   each marker the line state returns to the same reset values.
module fasta_fastq_format_sniffer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_fasta_single_line,
    output logic       is_fastq,
    output logic       is_fastx
);

    logic                     s1_valid_reg;
    logic [7:0]               s1_byte_reg;
    logic                     s1_eof_reg;
    logic                     s1_advance;
    logic                     s1_fire;
    logic                     out_valid_reg;
    logic                     fasta_reg;
    logic                     fastq_reg;
    fsniff_pkg::byte_class_t  byte_class;
    fsniff_pkg::verdict_t     verdict;

    assign s1_advance = !s1_eof_reg || !out_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_byte_reg <= 8'd0;
            s1_eof_reg  <= 1'b0;
        end
        else if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_eof_reg  <= end_of_file;
        end
    end

    fsniff_classify u_classify
    (
        .data_byte  (s1_byte_reg),
        .byte_class (byte_class)
    );

    fsniff_tracker u_tracker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_fire),
        .end_of_file (s1_eof_reg),
        .byte_class  (byte_class),
        .verdict     (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_eof_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fasta_reg <= 1'b0;
            fastq_reg <= 1'b0;
        end
        else if (s1_fire && s1_eof_reg)
        begin
            fasta_reg <= verdict.is_fasta;
            fastq_reg <= verdict.is_fastq;
        end
    end

    assign out_valid            = out_valid_reg;
    assign is_fasta_single_line = fasta_reg;
    assign is_fastq             = fastq_reg;
    assign is_fastx             = fasta_reg || fastq_reg;

endmodule

>>> hw/rtl/fsniff_classify.sv
// fsniff_classify: per-byte classification (newline, printable, nucleotide,
// header kind). Depends on fsniff_pkg.
module fsniff_classify
(
    input  logic [7:0]               data_byte,
    output fsniff_pkg::byte_class_t  byte_class
);

    logic [7:0] upper;

    always_comb
    begin
        // fold lower case onto upper case only for letters
        if (data_byte >= 8'h61 && data_byte <= 8'h7A)
        begin
            upper = data_byte & ~fsniff_pkg::CASE_BIT;
        end
        else
        begin
            upper = data_byte;
        end

        byte_class.newline    = (data_byte == fsniff_pkg::CHAR_NEWLINE);
        byte_class.printable  = (data_byte >= fsniff_pkg::CHAR_SPACE &&
                                 data_byte <= fsniff_pkg::CHAR_TILDE) ||
                                (data_byte == fsniff_pkg::CHAR_TAB);
        byte_class.nucleotide = (upper == fsniff_pkg::CHAR_A) ||
                                (upper == fsniff_pkg::CHAR_C) ||
                                (upper == fsniff_pkg::CHAR_G) ||
                                (upper == fsniff_pkg::CHAR_T) ||
                                (upper == fsniff_pkg::CHAR_N);

        priority if (data_byte == fsniff_pkg::CHAR_GT)
        begin
            byte_class.kind = fsniff_pkg::KIND_GT;
        end
        else if (data_byte == fsniff_pkg::CHAR_AT)
        begin
            byte_class.kind = fsniff_pkg::KIND_AT;
        end
        else if (data_byte == fsniff_pkg::CHAR_PLUS)
        begin
            byte_class.kind = fsniff_pkg::KIND_PLUS;
        end
        else
        begin
            byte_class.kind = fsniff_pkg::KIND_OTHER;
        end
    end

endmodule

>>> hw/rtl/fsniff_tracker.sv
// fsniff_tracker: line state of the current file and the end-of-file verdict.
// Depends on fsniff_pkg; fed by fsniff_classify.
module fsniff_tracker
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic                     end_of_file,
    input  fsniff_pkg::byte_class_t  byte_class,
    output fsniff_pkg::verdict_t     verdict
);

    logic [2:0]          line_index_reg,  line_index_next;
    logic [1:0]          line_length_reg, line_length_next;
    fsniff_pkg::kind_t   kind_reg,        kind_next;
    logic                prn_reg,         prn_next;
    logic                nuc_reg,         nuc_next;
    logic                fasta_ok_reg,    fasta_ok_next;
    logic                fastq_ok_reg,    fastq_ok_next;

    logic                active;
    logic                nonempty;
    logic                fasta_hdr, nuc_line, fq_hdr, plus_line;
    logic                do_close;
    logic                fa_closed, fq_closed;
    logic                fa_after,  fq_after;
    logic [2:0]          idx_after;

    always_comb
    begin
        active    = (line_index_reg < fsniff_pkg::LINE_LIMIT);
        nonempty  = (line_length_reg != 2'd0);
        fasta_hdr = (line_length_reg >= fsniff_pkg::LEN_MAX) &&
                    (kind_reg == fsniff_pkg::KIND_GT) && prn_reg;
        nuc_line  = nonempty && nuc_reg;
        fq_hdr    = nonempty && (kind_reg == fsniff_pkg::KIND_AT) && prn_reg;
        plus_line = nonempty && (kind_reg == fsniff_pkg::KIND_PLUS) && prn_reg;

        fa_closed = fasta_ok_reg;
        fq_closed = fastq_ok_reg;
        unique case (line_index_reg)
            3'd0:
            begin
                fa_closed = fasta_ok_reg && fasta_hdr;
                fq_closed = fastq_ok_reg && fq_hdr;
            end
            3'd1:
            begin
                fa_closed = fasta_ok_reg && nuc_line;
                fq_closed = fastq_ok_reg && nuc_line;
            end
            3'd2:
            begin
                fa_closed = fasta_ok_reg && fasta_hdr;
                fq_closed = fastq_ok_reg && plus_line;
            end
            3'd4:
            begin
                fq_closed = fastq_ok_reg && fq_hdr;
            end
            default:
            begin
            end
        endcase

        do_close  = active && (end_of_file ? nonempty : byte_class.newline);
        fa_after  = do_close ? fa_closed : fasta_ok_reg;
        fq_after  = do_close ? fq_closed : fastq_ok_reg;
        idx_after = line_index_reg + {2'd0, do_close};

        verdict.is_fasta = fa_after && (idx_after >= fsniff_pkg::FASTA_MIN_LINES);
        verdict.is_fastq = fq_after && (idx_after >= fsniff_pkg::FASTQ_MIN_LINES);

        line_index_next  = line_index_reg;
        line_length_next = line_length_reg;
        kind_next        = kind_reg;
        prn_next         = prn_reg;
        nuc_next         = nuc_reg;
        fasta_ok_next    = fasta_ok_reg;
        fastq_ok_next    = fastq_ok_reg;

        priority if (end_of_file)
        begin
            line_index_next  = 3'd0;
            line_length_next = 2'd0;
            kind_next        = fsniff_pkg::KIND_OTHER;
            prn_next         = 1'b1;
            nuc_next         = 1'b1;
            fasta_ok_next    = 1'b1;
            fastq_ok_next    = 1'b1;
        end
        else if (!active)
        begin
        end
        else if (byte_class.newline)
        begin
            line_index_next  = idx_after;
            line_length_next = 2'd0;
            kind_next        = fsniff_pkg::KIND_OTHER;
            prn_next         = 1'b1;
            nuc_next         = 1'b1;
            fasta_ok_next    = fa_after;
            fastq_ok_next    = fq_after;
        end
        else
        begin
            if (!nonempty)
            begin
                kind_next = byte_class.kind;
            end
            if (line_length_reg < fsniff_pkg::LEN_MAX)
            begin
                line_length_next = line_length_reg + 2'd1;
            end
            prn_next = prn_reg && byte_class.printable;
            nuc_next = nuc_reg && byte_class.nucleotide;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_index_reg  <= 3'd0;
            line_length_reg <= 2'd0;
            kind_reg        <= fsniff_pkg::KIND_OTHER;
            prn_reg         <= 1'b1;
            nuc_reg         <= 1'b1;
            fasta_ok_reg    <= 1'b1;
            fastq_ok_reg    <= 1'b1;
        end
        else if (step)
        begin
            line_index_reg  <= line_index_next;
            line_length_reg <= line_length_next;
            kind_reg        <= kind_next;
            prn_reg         <= prn_next;
            nuc_reg         <= nuc_next;
            fasta_ok_reg    <= fasta_ok_next;
            fastq_ok_reg    <= fastq_ok_next;
        end
    end

endmodule

>>> hw/rtl/fsniff_checker.sv
// fsniff_checker: port-level assertions for fasta_fastq_format_sniffer,
// attached by the bind statement below. Depends on the top level's ports.
module fsniff_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       end_of_file,
    input logic       out_valid,
    input logic       out_ready,
    input logic       is_fasta_single_line,
    input logic       is_fastq,
    input logic       is_fastx
);

    // a stalled verdict word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_fasta_single_line)
            && $stable(is_fastq))
        else $error("stalled verdict changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_fastx == (is_fasta_single_line || is_fastq)))
        else $error("is_fastx mismatch");

    // '>' and '@' first lines exclude each other
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_fasta_single_line && is_fastq))
        else $error("both verdicts set");

    // a data byte never raises a verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !end_of_file |-> ##2 !$rose(out_valid))
        else $error("verdict from a data byte");

endmodule

bind fasta_fastq_format_sniffer fsniff_checker u_fsniff_checker
(
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .end_of_file          (end_of_file),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .is_fasta_single_line (is_fasta_single_line),
    .is_fastq             (is_fastq),
    .is_fastx             (is_fastx)
);
